// ===== sv/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Port device detector package
// Shared types, constants and codes of the port device detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pdd_pkg;

	localparam int unsigned TICK_COUNT_BITS = 8;
	localparam int unsigned REG_W           = 8;
	localparam int unsigned CMP_W           = (TICK_COUNT_BITS > REG_W) ? TICK_COUNT_BITS : REG_W;
	localparam int unsigned ADC_W           = 12;
	localparam int unsigned MV_W            = 13;
	localparam int unsigned SCALE_W         = 13;
	localparam int unsigned PROD_W          = ADC_W + SCALE_W;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SCALE_W-1:0] MV_SCALE = SCALE_W'(5005);

	localparam logic [MV_W-1:0] MV_BAL_LO    = MV_W'(2400);
	localparam logic [MV_W-1:0] MV_BAL_HI    = MV_W'(2600);
	localparam logic [MV_W-1:0] MV_ERR_A_LO  = MV_W'(2800);
	localparam logic [MV_W-1:0] MV_ERR_A_HI  = MV_W'(3700);
	localparam logic [MV_W-1:0] MV_ERR_B_LO  = MV_W'(650);
	localparam logic [MV_W-1:0] MV_ERR_B_HI  = MV_W'(850);
	localparam logic [MV_W-1:0] MV_MED_LO    = MV_W'(250);
	localparam logic [MV_W-1:0] MV_MED_HI    = MV_W'(450);
	localparam logic [MV_W-1:0] MV_PIN5_ERR  = MV_W'(1600);
	localparam logic [MV_W-1:0] MV_PIN5_MED  = MV_W'(2000);
	localparam logic [MV_W-1:0] MV_SHORT     = MV_W'(100);
	localparam logic [MV_W-1:0] MV_DIFF_LIM  = MV_W'(50);

	typedef enum logic [1:0] {
		REG_SETTLE = 2'd0,
		REG_ADD    = 2'd1,
		REG_REMOVE = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_INIT       = 3'd0,
		PH_SETTLE     = 3'd1,
		PH_NO_DEVICE  = 3'd2,
		PH_PIN6_PROBE = 3'd3,
		PH_CLASSIFY   = 3'd4,
		PH_PIN5_PROBE = 3'd5,
		PH_CONNECTED  = 3'd6,
		PH_WAIT_DISC  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TACHO = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic            busy;
		logic            attached;
		logic            pin6_high;
		logic [MV_W-1:0] mv;
	} tick_t;

	typedef struct packed {
		logic       kind_changed;
		logic       motor_variant;
		logic [1:0] device_kind;
		logic       detach_request;
		logic       attach_request;
		logic       pin5_det_on;
		logic       pin6_drive_high;
		logic       float_pulse;
		logic [2:0] phase;
	} result_t;

	localparam int unsigned IN_BYTES_W  = 16;
	localparam int unsigned OUT_BYTES_W = 16;

endpackage

`default_nettype wire

// ===== sv/pdd_front.sv =====
// ----------------------------------------------------------------------------
// Port device detector front end
// Accepts tick transactions and scales the converter code to millivolts.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_front
	import pdd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ADC_W-1:0]  adc_code,
	input  wire logic              pin6_level,
	input  wire logic              driver_attached,
	input  wire logic              host_busy,
	output logic                   push,
	output tick_t                  push_data,
	input  wire logic              queue_full
);

	logic              valid_s1;
	tick_t             tick_s1;
	logic [PROD_W-1:0] prod;

	assign prod     = PROD_W'(adc_code) * PROD_W'(MV_SCALE);
	assign in_ready = !valid_s1 || !queue_full;
	assign push     = valid_s1 && !queue_full;
	assign push_data = tick_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1.mv        <= prod[PROD_W-1:ADC_W];
			tick_s1.pin6_high <= pin6_level;
			tick_s1.attached  <= driver_attached;
			tick_s1.busy      <= host_busy;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pdd_queue.sv =====
// ----------------------------------------------------------------------------
// Port device detector queue
// Short first-in first-out buffer between the front end and the detector.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_queue
	import pdd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire tick_t push_data,
	output logic       full,
	output logic       not_empty,
	input  wire logic  pop,
	output tick_t      pop_data
);

	tick_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("Queue count did not grow on a push.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("Queue count did not shrink on a pop.");

endmodule

`default_nettype wire

// ===== sv/pdd_back.sv =====
// ----------------------------------------------------------------------------
// Port device detector back end
// Runs the eight-phase connect and disconnect detector, one tick per cycle while the output register is free or read.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_back
	import pdd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [REG_W-1:0]  cfg_data,
	input  wire logic              tick_valid,
	input  wire tick_t             tick,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output result_t                out_data
);

	localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

	logic [REG_W-1:0]           settle_q;
	logic [REG_W-1:0]           add_q;
	logic [REG_W-1:0]           remove_q;

	phase_t                     phase_q, phase_d;
	logic [TICK_COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic [1:0]                 flags_q, flags_d, flags_new;
	logic [MV_W-1:0]            float_mv_q, float_mv_d;
	logic [MV_W-1:0]            low_mv_q, low_mv_d;
	kind_t                      kind_q, kind_d;
	logic                       variant_q, variant_d;
	logic                       pin6_q, pin6_d;
	logic                       pin5_q, pin5_d;
	logic                       flt_d, att_d, det_d;

	logic                       out_valid_q;
	result_t                    out_data_q;
	result_t                    result;

	logic                       balanced;
	logic [MV_W-1:0]            mv, fmv, mv_diff;
	logic                       near_equal;
	logic [CMP_W-1:0]           cnt_inc_w, cnt_mid_w, settle_w, add_w, remove_w;

	assign mv        = tick.mv;
	assign fmv       = float_mv_q;
	assign balanced  = (mv >= MV_BAL_LO) && (mv <= MV_BAL_HI);
	assign mv_diff   = (fmv >= low_mv_q) ? (fmv - low_mv_q) : (low_mv_q - fmv);
	assign near_equal = (mv_diff < MV_DIFF_LIM);
	assign cnt_inc   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_inc_w = CMP_W'(cnt_inc);
	assign settle_w  = CMP_W'(settle_q);
	assign add_w     = CMP_W'(add_q);
	assign remove_w  = CMP_W'(remove_q);
	assign flags_new = {!tick.pin6_high, !balanced};

	assign pop       = tick_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= REG_W'(2);
			add_q    <= REG_W'(35);
			remove_q <= REG_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE: settle_q <= cfg_data;
				REG_ADD:    add_q    <= cfg_data;
				REG_REMOVE: remove_q <= cfg_data;
				default:    settle_q <= settle_q;
			endcase
		end
	end

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_inc;
		cnt_mid_w  = cnt_inc_w;
		flags_d    = flags_q;
		float_mv_d = float_mv_q;
		low_mv_d   = low_mv_q;
		kind_d     = kind_q;
		variant_d  = variant_q;
		pin6_d     = pin6_q;
		pin5_d     = pin5_q;
		flt_d      = 1'b0;
		att_d      = 1'b0;
		det_d      = 1'b0;
		case (phase_q)
			PH_INIT: begin
				if (!tick.attached) begin
					flt_d   = 1'b1;
					pin6_d  = 1'b0;
					pin5_d  = 1'b0;
					cnt_d   = '0;
					kind_d  = KIND_NONE;
					phase_d = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (cnt_inc_w >= settle_w) begin
					cnt_d   = '0;
					phase_d = PH_NO_DEVICE;
				end
			end
			PH_NO_DEVICE: begin
				flags_d = flags_new;
				if (flags_new != flags_q) begin
					cnt_d     = '0;
					cnt_mid_w = '0;
				end
				if (flags_new != 2'b00 && cnt_mid_w >= add_w) begin
					float_mv_d = mv;
					cnt_d      = '0;
					pin6_d     = 1'b1;
					phase_d    = PH_PIN6_PROBE;
				end
			end
			PH_PIN6_PROBE: begin
				if (cnt_inc_w >= settle_w) begin
					low_mv_d = mv;
					cnt_d    = '0;
					pin6_d   = 1'b0;
					phase_d  = PH_CLASSIFY;
				end
			end
			PH_CLASSIFY: begin
				if (!near_equal) begin
					kind_d  = KIND_ERR;
					phase_d = PH_WAIT_DISC;
				end else if ((fmv >= MV_BAL_LO && fmv <= MV_BAL_HI && flags_q[1])
						|| (fmv < MV_SHORT)
						|| (fmv >= MV_ERR_B_LO && fmv <= MV_ERR_B_HI)
						|| (fmv >= MV_ERR_A_LO && fmv <= MV_ERR_A_HI)) begin
					kind_d  = KIND_ERR;
					phase_d = PH_WAIT_DISC;
				end else if (fmv < MV_BAL_LO) begin
					kind_d    = KIND_TACHO;
					variant_d = (fmv > MV_MED_LO) && (fmv <= MV_MED_HI);
					phase_d   = PH_CONNECTED;
				end else begin
					pin5_d  = 1'b1;
					cnt_d   = '0;
					phase_d = PH_PIN5_PROBE;
				end
			end
			PH_PIN5_PROBE: begin
				if (cnt_inc_w >= settle_w) begin
					low_mv_d = mv;
					cnt_d    = '0;
					pin5_d   = 1'b0;
					if (mv < MV_PIN5_ERR) begin
						kind_d  = KIND_ERR;
						phase_d = PH_WAIT_DISC;
					end else begin
						kind_d    = KIND_TACHO;
						variant_d = (mv < MV_PIN5_MED);
						phase_d   = PH_CONNECTED;
					end
				end
			end
			PH_CONNECTED: begin
				cnt_d = '0;
				if (kind_q != KIND_ERR && !tick.busy) begin
					att_d   = 1'b1;
					phase_d = PH_WAIT_DISC;
				end
			end
			PH_WAIT_DISC: begin
				if (!balanced) begin
					cnt_d     = '0;
					cnt_mid_w = '0;
				end
				if (cnt_mid_w >= remove_w && !tick.busy) begin
					det_d   = 1'b1;
					phase_d = PH_INIT;
				end
			end
			default: begin
				phase_d = PH_INIT;
			end
		endcase
	end

	always_comb begin
		result.phase           = phase_d;
		result.float_pulse     = flt_d;
		result.pin6_drive_high = pin6_d;
		result.pin5_det_on     = pin5_d;
		result.attach_request  = att_d;
		result.detach_request  = det_d;
		result.device_kind     = kind_d;
		result.motor_variant   = variant_d;
		result.kind_changed    = (kind_d != kind_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			cnt_q       <= '0;
			flags_q     <= '0;
			float_mv_q  <= '0;
			low_mv_q    <= '0;
			kind_q      <= KIND_NONE;
			variant_q   <= 1'b0;
			pin6_q      <= 1'b0;
			pin5_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				flags_q     <= flags_d;
				float_mv_q  <= float_mv_d;
				low_mv_q    <= low_mv_d;
				kind_q      <= kind_d;
				variant_q   <= variant_d;
				pin6_q      <= pin6_d;
				pin5_q      <= pin5_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= result;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pin6_q |-> phase_q == PH_PIN6_PROBE)
		else $error("Pin 6 is driven outside the pin-6 probe.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pin5_q |-> phase_q == PH_PIN5_PROBE)
		else $error("Pin-5 detect is on outside the pin-5 probe.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("A detector step left no result in the output register.");

endmodule

`default_nettype wire

// ===== sv/port_device_detector.sv =====
// ----------------------------------------------------------------------------
// Port device detector
// Connect and disconnect detector for one output port, one poll tick each.
// ----------------------------------------------------------------------------
// Each tick transaction on the s_axis channel carries the pin-5 converter
// code, the pin-6 level and the host flags. Every tick yields exactly one
// result transaction on the m_axis channel with the detector phase, the pin
// controls, attach and detach pulses and the device kind.
// From acceptance, the scaled tick moves from the front register into the
// queue, and the detector step then takes it from the queue and fills the
// output register.
// One tick is accepted and stepped per cycle while m_axis_tready is high.
// A four-entry queue sits between the scaling front end and the detector, and
// the result sits in an output register, so a new tick is still accepted
// while a result waits. When m_axis_tready stays low the output register,
// the queue and then the front register fill, and s_axis_tready drops only
// once all of them are full.
// Reset clears the detector to its init phase and restores the default
// settle, add and remove tick counts. The cfg port writes them and is to be
// used only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module port_device_detector
	import pdd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [REG_W-1:0]       cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// adc_code[11:0], pin6_level[12], driver_attached[13], host_busy[14]
	input  wire logic [IN_BYTES_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// phase[2:0], float_pulse[3], pin6_drive_high[4], pin5_det_on[5],
	// attach_request[6], detach_request[7], device_kind[9:8],
	// motor_variant[10], kind_changed[11]
	output logic [OUT_BYTES_W-1:0]      m_axis_tdata
);

	logic    push;
	tick_t   push_data;
	logic    queue_full;
	logic    queue_valid;
	logic    pop;
	tick_t   pop_data;
	result_t out_data;

	pdd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.adc_code        (s_axis_tdata[ADC_W-1:0]),
		.pin6_level      (s_axis_tdata[12]),
		.driver_attached (s_axis_tdata[13]),
		.host_busy       (s_axis_tdata[14]),
		.push            (push),
		.push_data       (push_data),
		.queue_full      (queue_full)
	);

	pdd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.not_empty (queue_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	pdd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (queue_valid),
		.tick       (pop_data),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (out_data)
	);

	assign m_axis_tdata = OUT_BYTES_W'(out_data);

endmodule

`default_nettype wire

// ===== sim/port_device_detector_tb.sv =====
// ----------------------------------------------------------------------------
// Port device detector testbench
// Drives poll ticks through the detector and checks every result against a
// cycle-free prediction of the eight-phase connect and disconnect walk.
// ----------------------------------------------------------------------------
// Stimulus follows the predicted phase, so most ticks form plausible device
// sessions with random voltages: steady pin activity, a second pin-5 sample,
// a pin-5 probe reading and a balanced line for removal. Random noise, host
// busy flags and attached flags break the sessions up. The run steps through
// several threshold settings, from all zeros to 255, with random idle bursts
// on both stream sides and a quiet stretch at the end.
// ----------------------------------------------------------------------------
`default_nettype none

import pdd_pkg::*;

class detector_tracker;

	localparam int unsigned TICK_MAX = (1 << TICK_COUNT_BITS) - 1;

	logic [REG_W-1:0] settle;
	logic [REG_W-1:0] add;
	logic [REG_W-1:0] remove;

	phase_t           ph;
	int unsigned      ticks;
	logic [1:0]       activity;
	logic [MV_W-1:0]  float_mv;
	logic [MV_W-1:0]  low_mv;
	kind_t            kind;
	logic             variant;
	logic             drive6;
	logic             det5;

	result_t          predicted_q[$];
	int               faults;
	int               checked;
	int               attaches;
	int               detaches;
	int               bad_devices;

	function new();
		settle      = REG_W'(2);
		add         = REG_W'(35);
		remove      = REG_W'(10);
		ph          = PH_INIT;
		ticks       = 0;
		activity    = '0;
		float_mv    = '0;
		low_mv      = '0;
		kind        = KIND_NONE;
		variant     = 1'b0;
		drive6      = 1'b0;
		det5        = 1'b0;
		faults      = 0;
		checked     = 0;
		attaches    = 0;
		detaches    = 0;
		bad_devices = 0;
	endfunction

	function logic [MV_W-1:0] to_mv(logic [ADC_W-1:0] code);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(code) * PROD_W'(MV_SCALE);
		return prod[PROD_W-1:12];
	endfunction

	function void set_reg(logic [1:0] idx, logic [REG_W-1:0] value);
		case (idx)
			REG_SETTLE: settle = value;
			REG_ADD:    add = value;
			REG_REMOVE: remove = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return predicted_q.size();
	endfunction

	function void flag(string what, int want, int got);
		faults++;
		if (faults <= 10) begin
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				what, checked, want, got);
		end
	endfunction

	function void note_tick(logic [ADC_W-1:0] code, logic pin6, logic att, logic busy);
		logic [MV_W-1:0] mv;
		logic            bal;
		logic [1:0]      nf;
		kind_t           prior;
		result_t         r;
		int              diff;
		logic            fault;

		mv    = to_mv(code);
		bal   = (mv >= MV_BAL_LO) && (mv <= MV_BAL_HI);
		prior = kind;
		r     = '0;
		fault = 1'b0;

		if (ticks < TICK_MAX)
			ticks++;

		case (ph)
			PH_INIT: begin
				if (!att) begin
					r.float_pulse = 1'b1;
					drive6 = 1'b0;
					det5 = 1'b0;
					ticks = 0;
					kind = KIND_NONE;
					ph = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (ticks >= settle) begin
					ticks = 0;
					ph = PH_NO_DEVICE;
				end
			end
			PH_NO_DEVICE: begin
				nf = {~pin6, ~bal};
				if (nf != activity) begin
					activity = nf;
					ticks = 0;
				end
				if (activity != 2'b00 && ticks >= add) begin
					float_mv = mv;
					ticks = 0;
					drive6 = 1'b1;
					ph = PH_PIN6_PROBE;
				end
			end
			PH_PIN6_PROBE: begin
				if (ticks >= settle) begin
					low_mv = mv;
					ticks = 0;
					drive6 = 1'b0;
					ph = PH_CLASSIFY;
				end
			end
			PH_CLASSIFY: begin
				diff = int'(float_mv) - int'(low_mv);
				if (diff <= -int'(MV_DIFF_LIM) || diff >= int'(MV_DIFF_LIM))
					fault = 1'b1;
				else if (float_mv >= MV_BAL_LO && float_mv <= MV_BAL_HI && activity[1])
					fault = 1'b1;
				else if (float_mv < MV_SHORT)
					fault = 1'b1;
				else if (float_mv >= MV_ERR_B_LO && float_mv <= MV_ERR_B_HI)
					fault = 1'b1;
				else if (float_mv >= MV_ERR_A_LO && float_mv <= MV_ERR_A_HI)
					fault = 1'b1;
				else if (float_mv < MV_BAL_LO) begin
					kind = KIND_TACHO;
					variant = (float_mv > MV_MED_LO) && (float_mv <= MV_MED_HI);
					ph = PH_CONNECTED;
				end else begin
					det5 = 1'b1;
					ticks = 0;
					ph = PH_PIN5_PROBE;
				end
				if (fault) begin
					kind = KIND_ERR;
					ph = PH_WAIT_DISC;
				end
			end
			PH_PIN5_PROBE: begin
				if (ticks >= settle) begin
					low_mv = mv;
					ticks = 0;
					det5 = 1'b0;
					if (mv < MV_PIN5_ERR) begin
						kind = KIND_ERR;
						ph = PH_WAIT_DISC;
					end else begin
						kind = KIND_TACHO;
						variant = (mv < MV_PIN5_MED);
						ph = PH_CONNECTED;
					end
				end
			end
			PH_CONNECTED: begin
				ticks = 0;
				if (kind != KIND_ERR && !busy) begin
					r.attach_request = 1'b1;
					ph = PH_WAIT_DISC;
				end
			end
			default: begin
				if (!bal)
					ticks = 0;
				if (ticks >= remove && !busy) begin
					r.detach_request = 1'b1;
					ph = PH_INIT;
				end
			end
		endcase

		r.phase           = ph;
		r.pin6_drive_high = drive6;
		r.pin5_det_on     = det5;
		r.device_kind     = kind;
		r.motor_variant   = variant;
		r.kind_changed    = (kind != prior);

		attaches += r.attach_request;
		detaches += r.detach_request;
		if (kind == KIND_ERR && prior != KIND_ERR)
			bad_devices++;
		predicted_q.push_back(r);
	endfunction

	function void check_result(logic [OUT_BYTES_W-1:0] data);
		result_t got;
		result_t want;

		got = result_t'(data[$bits(result_t)-1:0]);
		if (predicted_q.size() == 0) begin
			flag("unexpected result", 0, int'(data));
		end else begin
			want = predicted_q.pop_front();
			if (got.phase != want.phase)
				flag("phase", want.phase, got.phase);
			if (got.float_pulse != want.float_pulse)
				flag("float_pulse", want.float_pulse, got.float_pulse);
			if (got.pin6_drive_high != want.pin6_drive_high)
				flag("pin6_drive_high", want.pin6_drive_high, got.pin6_drive_high);
			if (got.pin5_det_on != want.pin5_det_on)
				flag("pin5_det_on", want.pin5_det_on, got.pin5_det_on);
			if (got.attach_request != want.attach_request)
				flag("attach_request", want.attach_request, got.attach_request);
			if (got.detach_request != want.detach_request)
				flag("detach_request", want.detach_request, got.detach_request);
			if (got.device_kind != want.device_kind)
				flag("device_kind", want.device_kind, got.device_kind);
			if (got.motor_variant != want.motor_variant)
				flag("motor_variant", want.motor_variant, got.motor_variant);
			if (got.kind_changed != want.kind_changed)
				flag("kind_changed", want.kind_changed, got.kind_changed);
		end
		checked++;
	endfunction

	function void close_out();
		if (predicted_q.size() != 0)
			flag("results never delivered", 0, predicted_q.size());
	endfunction

endclass

module port_device_detector_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [ADC_W-1:0] flt_code;
		logic [ADC_W-1:0] low_code;
		logic [ADC_W-1:0] pin5_code;
		logic             pin6;
		int               busy_pct;
		int               noise_pct;
	} session_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [REG_W-1:0]       cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_BYTES_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_BYTES_W-1:0] m_axis_tdata;

	detector_tracker sb;
	int              stim_count = 0;
	bit              calm = 1'b0;

	port_device_detector DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_axis_tready = 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 4);
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	function automatic logic [ADC_W-1:0] code_for(int mv);
		int c;
		if (mv < 0)
			mv = 0;
		c = (mv * 4096 + 5004) / 5005;
		if (c > 4095)
			c = 4095;
		return ADC_W'(c);
	endfunction

	function automatic session_t make_session(int noise);
		session_t s;
		int       f;
		int       delta;

		s.pin6 = $urandom_range(0, 1);
		case ($urandom_range(0, 9))
			0: f = $urandom_range(0, 99);
			1: f = $urandom_range(100, 649);
			2: f = $urandom_range(250, 450);
			3: f = $urandom_range(650, 850);
			4: f = $urandom_range(851, 2399);
			5: f = $urandom_range(2400, 2600);
			6: f = $urandom_range(2601, 2799);
			7: f = $urandom_range(2800, 3700);
			8: f = $urandom_range(3701, 5003);
			default: f = -1;
		endcase
		s.flt_code = (f < 0) ? ADC_W'($urandom_range(0, 4095)) : code_for(f);
		f = int'(sb.to_mv(s.flt_code));
		if (f >= int'(MV_BAL_LO) && f <= int'(MV_BAL_HI))
			s.pin6 = 1'b0;

		if ($urandom_range(0, 4) == 0)
			delta = $urandom_range(50, 400);
		else
			delta = $urandom_range(0, 40);
		if ($urandom_range(0, 1) == 1)
			delta = -delta;
		s.low_code = code_for(f + delta);

		case ($urandom_range(0, 3))
			0: s.pin5_code = code_for($urandom_range(0, 1599));
			1: s.pin5_code = code_for($urandom_range(1600, 1999));
			2: s.pin5_code = code_for($urandom_range(2000, 5003));
			default: s.pin5_code = $urandom_range(0, 4095);
		endcase

		s.busy_pct  = $urandom_range(0, 60);
		s.noise_pct = noise;
		return s;
	endfunction

	function automatic session_t fixed_session(logic [ADC_W-1:0] flt, logic pin6,
			logic [ADC_W-1:0] low, logic [ADC_W-1:0] pin5, int busy_pct);
		session_t s;
		s.flt_code  = flt;
		s.pin6      = pin6;
		s.low_code  = low;
		s.pin5_code = pin5;
		s.busy_pct  = busy_pct;
		s.noise_pct = 0;
		return s;
	endfunction

	task automatic send_tick(logic [ADC_W-1:0] code, logic pin6, logic att, logic busy);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {1'b0, busy, att, pin6, code};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_tick(code, pin6, att, busy);
		stim_count++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic apply_settings(int settle, int add, int remove);
		drain();
		write_reg(REG_SETTLE, REG_W'(settle));
		write_reg(REG_ADD, REG_W'(add));
		write_reg(REG_REMOVE, REG_W'(remove));
	endtask

	task automatic run_session(session_t s, int stop_at);
		logic [ADC_W-1:0] code;
		logic             pin6;
		logic             att;
		logic             busy;
		phase_t           was;
		bit               done;

		done = 1'b0;
		while (!done && stim_count < stop_at) begin
			code = $urandom_range(0, 4095);
			pin6 = $urandom_range(0, 1);
			att  = $urandom_range(0, 1);
			busy = $urandom_range(0, 1);
			case (sb.ph)
				PH_INIT:       att = ($urandom_range(0, 99) < 25);
				PH_NO_DEVICE: begin
					if ($urandom_range(0, 99) >= s.noise_pct) begin
						code = s.flt_code;
						pin6 = s.pin6;
					end
				end
				PH_PIN6_PROBE: code = s.low_code;
				PH_PIN5_PROBE: code = s.pin5_code;
				PH_CONNECTED:  busy = ($urandom_range(0, 99) < s.busy_pct);
				PH_WAIT_DISC: begin
					busy = ($urandom_range(0, 99) < s.busy_pct);
					if ($urandom_range(0, 9) != 0)
						code = code_for($urandom_range(2400, 2598));
				end
				default: ;
			endcase
			was = sb.ph;
			send_tick(code, pin6, att, busy);
			done = (was == PH_WAIT_DISC && sb.ph == PH_INIT);
		end
	endtask

	task automatic run_phase(int items, int noise);
		int stop_at;
		stop_at = stim_count + items;
		while (stim_count < stop_at)
			run_session(make_session(noise), stop_at);
	endtask

	initial begin
		int guard;

		sb            = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SETTLE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero thresholds let each directed session pass through in a few ticks.
		apply_settings(0, 0, 0);
		write_reg(REG_UNUSED, 8'hA5);
		run_session(fixed_session(12'hFFF, 1'b1, 12'hFFF, 12'h000, 0), stim_count + 12);
		run_session(fixed_session(code_for(1000), 1'b0, code_for(1100), 12'h000, 0),
			stim_count + 12);
		run_session(fixed_session(code_for(350), 1'b1, code_for(350), 12'h000, 50),
			stim_count + 12);
		run_session(fixed_session(code_for(2700), 1'b1, code_for(2705), code_for(1800), 0),
			stim_count + 12);

		apply_settings(1, 1, 1);
		run_phase(150, 10);

		apply_settings($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
		run_phase(75, 5);
		drain();
		run_phase(75, 5);

		apply_settings(2, 35, 10);
		run_phase(150, 1);

		apply_settings(3, 255, 3);
		run_phase(300, 0);

		apply_settings(255, 1, 255);
		run_phase(50, 5);

		calm = 1'b1;
		apply_settings($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
		run_phase(150, 5);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		sb.close_out();

		$display("Sent %0d ticks under seven threshold settings from all zeros to 255; %0d results checked.",
			stim_count, sb.checked);
		$display("Detector raised %0d attach and %0d detach requests and flagged %0d bad devices; %0d mismatches.",
			sb.attaches, sb.detaches, sb.bad_devices, sb.faults);
		if (sb.faults == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/pdd_pkg.sv
sv/pdd_front.sv
sv/pdd_queue.sv
sv/pdd_back.sv
sv/port_device_detector.sv
sim/port_device_detector_tb.sv
